// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define QCTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define QCTP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/qctp_pkg.sv =====
// Types and constants shared by the quad channel touch position block.
package qctp_pkg;

  localparam int unsigned READING_BITS = 28;
  localparam int unsigned PREP_W       = READING_BITS + 1;
  localparam int unsigned GAIN_W       = 24;
  localparam int unsigned SHIFT_W      = 5;
  localparam int unsigned MASK_W       = 4;
  localparam int unsigned NUM_CH       = 4;
  localparam int unsigned CH_IDX_W     = 2;
  localparam int unsigned OVF_BIT      = 26;
  localparam int unsigned POS_W        = 40;
  localparam int unsigned FORCE_W      = 37;

  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 5;
  localparam int unsigned REG_IDX_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_SHIFT_AMOUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GUARD_MASK   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_CH0     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_CH1     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_CH2     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_CH3     = 3'd5;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 24'sd65536;

  typedef struct packed {
    logic [READING_BITS-1:0] reading_a;
    logic [READING_BITS-1:0] reading_b;
    logic [READING_BITS-1:0] reading_c;
    logic [READING_BITS-1:0] reading_d;
  } qctp_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [FORCE_W-1:0]      touch_force;
    logic                    force_clamped;
  } qctp_out_t;

endpackage

// ===== rtl/qctp_weigh.sv =====
// One channel: overflow-bit correction, right shift and gain multiply.
module qctp_weigh import qctp_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = 16,
  parameter int unsigned MAG_W          = PREP_W + GAIN_W - GAIN_FRAC_BITS
) (
  input  logic [READING_BITS-1:0] raw_i,
  input  logic                    guard_i,
  input  logic [SHIFT_W-1:0]      shift_i,
  input  logic signed [GAIN_W-1:0] gain_i,
  output logic [MAG_W-1:0]        mag_o,
  output logic                    neg_o
);

  localparam int unsigned PROD_W = PREP_W + GAIN_W;

  logic [PREP_W-1:0] prep;
  logic [PREP_W-1:0] shifted;
  logic [GAIN_W-1:0] gain_mag;
  logic [PROD_W-1:0] prod;

  // A set guard bit doubles the reading unless the overflow bit is already up.
  always_comb begin
    if (guard_i && !raw_i[OVF_BIT]) begin
      prep = {raw_i, 1'b0};
    end else begin
      prep = {1'b0, raw_i};
    end
  end

  assign shifted  = prep >> shift_i;
  // The most negative gain gives 2^23, which still fits unsigned.
  assign gain_mag = gain_i[GAIN_W-1] ? (~gain_i + 1'b1) : gain_i;
  assign prod     = PROD_W'(shifted) * PROD_W'(gain_mag);

  // Working on magnitudes makes the fraction drop truncate toward zero.
  assign mag_o = prod[PROD_W-1:GAIN_FRAC_BITS];
  assign neg_o = gain_i[GAIN_W-1];

endmodule

// ===== rtl/quad_channel_touch_position.sv =====
// Top level of the quad channel touch position block with its register file.
// An accepted item passes the input register and stage two, then the result register.
// Throughput: one item per cycle while the receiver takes results; else the stages stall.
// Stages: input register, weighted channel magnitudes, result register; each stalls alone.
// Reset clears all valid flags, sets shift_amount and guard_mask to 0 and every gain to 1.0.
module quad_channel_touch_position import qctp_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input item channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  qctp_in_t              in_data_i,
  // Result item channel.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output qctp_out_t             out_data_o,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Width of one weighted magnitude, and of the signed sums built from four of them.
  localparam int unsigned MAG_W = PREP_W + GAIN_W - GAIN_FRAC_BITS;
  localparam int unsigned SUM_W = MAG_W + 3;
  localparam int unsigned EXT_W = (SUM_W > POS_W) ? SUM_W : POS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes only arrive while the pipeline is empty: the user
  // must keep to this, the block does not enforce it, and the datapath reads them directly.
  // ---------------------------------------------------------------------------
  logic [SHIFT_W-1:0]       shift_q;
  logic [MASK_W-1:0]        guard_q;
  logic signed [GAIN_W-1:0] gain_q [NUM_CH];
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      guard_q <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        gain_q[i] <= GAIN_RESET;
      end
    end else if (cfg_we) begin
      case (reg_idx)
        REG_SHIFT_AMOUNT: shift_q <= pwdata[SHIFT_W-1:0];
        REG_GUARD_MASK:   guard_q <= pwdata[MASK_W-1:0];
        REG_GAIN_CH0, REG_GAIN_CH1, REG_GAIN_CH2, REG_GAIN_CH3: begin
          gain_q[CH_IDX_W'(reg_idx - REG_GAIN_CH0)] <= pwdata[GAIN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Read data is decoded straight from the address; unused addresses read zero.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SHIFT_AMOUNT: prdata = APB_DATA_W'(shift_q);
      REG_GUARD_MASK:   prdata = APB_DATA_W'(guard_q);
      REG_GAIN_CH0, REG_GAIN_CH1, REG_GAIN_CH2, REG_GAIN_CH3: begin
        prdata = APB_DATA_W'(gain_q[CH_IDX_W'(reg_idx - REG_GAIN_CH0)]);
      end
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or when its item
  // moves on in the same cycle, so new items fill the empty stages behind a waiting result.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_load, s2_load, out_load;

  assign out_load   = !out_valid_q || out_ready_i;
  assign s2_load    = !s2_valid_q || out_load;
  assign s1_load    = !s1_valid_q || s2_load;
  assign in_ready_o = s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_load) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_load) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage one: input register.
  // ---------------------------------------------------------------------------
  qctp_in_t s1_q;

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage two: each channel is corrected, shifted and weighted. The magnitude
  // and the sign of the gain are kept apart until the sums.
  // ---------------------------------------------------------------------------
  logic [READING_BITS-1:0] raw      [NUM_CH];
  logic [MAG_W-1:0]        mag      [NUM_CH];
  logic                    neg      [NUM_CH];
  logic [MAG_W-1:0]        mag_q    [NUM_CH];
  logic                    neg_q    [NUM_CH];

  assign raw[0] = s1_q.reading_a;
  assign raw[1] = s1_q.reading_b;
  assign raw[2] = s1_q.reading_c;
  assign raw[3] = s1_q.reading_d;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
    qctp_weigh #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .MAG_W          (MAG_W)
    ) u_weigh (
      .raw_i   (raw[g]),
      .guard_i (guard_q[g]),
      .shift_i (shift_q),
      .gain_i  (gain_q[g]),
      .mag_o   (mag[g]),
      .neg_o   (neg[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_q) begin
      for (int i = 0; i < NUM_CH; i++) begin
        mag_q[i] <= mag[i];
        neg_q[i] <= neg[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage three: signed weighted values, position sums and force. Sums carry
  // enough bits that nothing wraps before the output fields are cut out.
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] d [NUM_CH];
  logic signed [SUM_W-1:0] x_sum, y_sum, f_sum;
  logic signed [EXT_W-1:0] x_ext, y_ext, f_ext;
  qctp_out_t               out_d, out_q;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      d[i] = neg_q[i] ? -$signed(SUM_W'(mag_q[i])) : $signed(SUM_W'(mag_q[i]));
    end
    x_sum = -d[0] - d[1] + d[2] + d[3];
    y_sum =  d[0] - d[1] - d[2] + d[3];
    f_sum =  d[0] + d[1] + d[2] + d[3];
    x_ext = EXT_W'(x_sum);
    y_ext = EXT_W'(y_sum);
    f_ext = EXT_W'(f_sum);

    out_d.pos_x = x_ext[POS_W-1:0];
    out_d.pos_y = y_ext[POS_W-1:0];
    // A negative sum, even one whose quarter would truncate to zero, is clamped.
    if (f_sum[SUM_W-1]) begin
      out_d.touch_force   = '0;
      out_d.force_clamped = 1'b1;
    end else begin
      out_d.touch_force   = f_ext[2 +: FORCE_W];
      out_d.force_clamped = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/qctp_sva.sv =====
// Port-level checker for the quad channel touch position block, with its bind.
`include "assert_macros.svh"

module qctp_sva import qctp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input qctp_out_t out_data_o,
  input logic      pready
);

  // A stalled result stays offered and unchanged.
  `QCTP_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o),
    "stalled result changed")

  // The configuration port never inserts wait states.
  `QCTP_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

  // A clamped force always reads as zero.
  `QCTP_ASSERT(a_clamp_zero,
    out_valid_o && out_data_o.force_clamped |-> out_data_o.touch_force == '0,
    "clamped force not zero")

  // x and y differ by twice (d2 - d0), so their low bits always agree.
  `QCTP_ASSERT(a_xy_parity,
    out_valid_o |-> out_data_o.pos_x[0] == out_data_o.pos_y[0],
    "x and y parity differ")

endmodule

bind quad_channel_touch_position qctp_sva u_qctp_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

// ===== bench/quad_channel_touch_position_checker.sv =====
// Checker that predicts and compares the result items of the touch position block.
module quad_channel_touch_position_checker import qctp_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  qctp_in_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  qctp_out_t             out_data_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int unsigned           fail_count_o,
  output int unsigned           outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  logic [SHIFT_W-1:0]       shift_q;
  logic [MASK_W-1:0]        guard_q;
  logic signed [GAIN_W-1:0] gain_q [NUM_CH];

  qctp_out_t   expected_positions [$];
  int unsigned mismatch_total;
  int unsigned results_seen;

  // Weighted value of one channel: optional doubling, shift, signed gain, truncation to zero.
  function automatic longint weigh_channel(logic [READING_BITS-1:0] raw, int unsigned ch);
    logic [PREP_W-1:0]        prep;
    logic signed [GAIN_W-1:0] gain;
    logic [GAIN_W-1:0]        gain_mag;
    longint unsigned          prod;
    prep = PREP_W'(raw);
    if (guard_q[ch] && !raw[OVF_BIT]) begin
      prep = prep << 1;
    end
    prep = prep >> shift_q;
    gain = gain_q[ch];
    gain_mag = gain[GAIN_W-1] ? GAIN_W'(-gain) : GAIN_W'(gain);
    prod = 64'(prep) * 64'(gain_mag);
    prod = prod >> GAIN_FRAC_BITS;
    return gain[GAIN_W-1] ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic qctp_out_t predict_position(qctp_in_t item);
    longint    d0, d1, d2, d3;
    longint    x, y, sum;
    qctp_out_t want;
    d0 = weigh_channel(item.reading_a, 0);
    d1 = weigh_channel(item.reading_b, 1);
    d2 = weigh_channel(item.reading_c, 2);
    d3 = weigh_channel(item.reading_d, 3);
    x = -d0 - d1 + d2 + d3;
    y = d0 - d1 - d2 + d3;
    sum = d0 + d1 + d2 + d3;
    want.pos_x = POS_W'(x);
    want.pos_y = POS_W'(y);
    // A negative sum floors the force at zero, even when its quarter would truncate to zero.
    want.force_clamped = (sum < 0);
    want.touch_force = (sum < 0) ? '0 : FORCE_W'(sum / 4);
    return want;
  endfunction

  task automatic note_mismatch(string what, longint want, longint got);
    mismatch_total++;
    if (mismatch_total <= REPORT_LIMIT) begin
      $display("%0t: result %0d %s: expected %0d, got %0d", $realtime, results_seen, what,
               want, got);
    end
  endtask

  task automatic check_position(qctp_out_t got);
    qctp_out_t want;
    if (expected_positions.size() == 0) begin
      mismatch_total++;
      if (mismatch_total <= REPORT_LIMIT) begin
        $display("%0t: result item with no expectation waiting", $realtime);
      end
      return;
    end
    want = expected_positions.pop_front();
    if (got.pos_x !== want.pos_x) begin
      note_mismatch("pos_x", longint'(want.pos_x), longint'(got.pos_x));
    end
    if (got.pos_y !== want.pos_y) begin
      note_mismatch("pos_y", longint'(want.pos_y), longint'(got.pos_y));
    end
    if (got.touch_force !== want.touch_force) begin
      note_mismatch("touch_force", longint'(want.touch_force), longint'(got.touch_force));
    end
    if (got.force_clamped !== want.force_clamped) begin
      note_mismatch("force_clamped", longint'(want.force_clamped),
                    longint'(got.force_clamped));
    end
  endtask

  task automatic apply_register_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
    case (idx)
      REG_SHIFT_AMOUNT: shift_q = value[SHIFT_W-1:0];
      REG_GUARD_MASK:   guard_q = value[MASK_W-1:0];
      REG_GAIN_CH0:     gain_q[0] = value[GAIN_W-1:0];
      REG_GAIN_CH1:     gain_q[1] = value[GAIN_W-1:0];
      REG_GAIN_CH2:     gain_q[2] = value[GAIN_W-1:0];
      REG_GAIN_CH3:     gain_q[3] = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q = '0;
      guard_q = '0;
      foreach (gain_q[ch]) gain_q[ch] = GAIN_RESET;
      expected_positions.delete();
      mismatch_total = 0;
      results_seen = 0;
      fail_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        apply_register_write(paddr[APB_ADDR_W-1:2], pwdata);
      end
      if (out_valid_i && out_ready_i) begin
        check_position(out_data_i);
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_positions.push_back(predict_position(in_data_i));
      end
      fail_count_o <= mismatch_total;
      outstanding_o <= expected_positions.size();
    end
  end

endmodule

// ===== bench/quad_channel_touch_position_tb.sv =====
// Top of the touch position testbench: clock, reset, stimulus, receiver stalls and verdict.
module quad_channel_touch_position_tb import qctp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GAIN_FRAC = 16;
  // Register slots past the last gain; writes there must leave every setting alone.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [READING_BITS-1:0] READING_MAX = '1;
  localparam logic [READING_BITS-1:0] OVF_ONLY    = READING_BITS'(1) << OVF_BIT;
  localparam logic [READING_BITS-1:0] OVF_BELOW   = OVF_ONLY - READING_BITS'(1);
  localparam logic [READING_BITS-1:0] PATTERN_A   = 28'hAAAAAAA;
  localparam logic [READING_BITS-1:0] PATTERN_B   = 28'h5555555;

  localparam int unsigned SEGMENTS       = 8;
  localparam int unsigned SEGMENT_ITEMS  = 125;
  localparam int unsigned HOLD_AT_ITEM   = 400;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned SETTLE_CYCLES  = 20;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  qctp_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  qctp_out_t             out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned fail_count;
  int unsigned outstanding;
  // Number of accepted input items; read by the receiver to time its long hold-off.
  int unsigned items_sent;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  quad_channel_touch_position #(
    .GAIN_FRAC_BITS(GAIN_FRAC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  quad_channel_touch_position_checker #(
    .GAIN_FRAC_BITS(GAIN_FRAC)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  // Gaps between items: mostly none, some short, a few long. In a burst segment there are none.
  function automatic int unsigned pick_gap(bit burst);
    int unsigned roll;
    if (burst) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Readings lean toward the extremes and toward the overflow bit being set or clear.
  function automatic logic [READING_BITS-1:0] pick_reading();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return READING_MAX;
      2: return OVF_ONLY;
      3: return ~OVF_ONLY;
      4: return READING_BITS'($urandom) | OVF_ONLY;
      5: return READING_BITS'($urandom) & ~OVF_ONLY;
      default: return READING_BITS'($urandom);
    endcase
  endfunction

  // A gain word carries junk above the 24-bit field, which the block must ignore.
  function automatic logic [APB_DATA_W-1:0] pick_gain_word();
    logic signed [GAIN_W-1:0] gain;
    case ($urandom_range(0, 9))
      0: gain = 24'sh800000;
      1: gain = 24'sh7FFFFF;
      2: gain = '0;
      3: gain = GAIN_RESET;
      4: gain = -GAIN_RESET;
      5: gain = GAIN_W'($urandom_range(0, 511)) - GAIN_W'(256);
      default: gain = GAIN_W'($urandom);
    endcase
    return {8'($urandom), gain};
  endfunction

  function automatic logic [APB_DATA_W-1:0] pick_shift_word();
    logic [SHIFT_W-1:0] shift;
    // Mostly small shifts, so that the weighted values stay large enough to mean something.
    shift = ($urandom_range(0, 9) == 0) ? SHIFT_W'($urandom_range(0, 31))
                                        : SHIFT_W'($urandom_range(0, 4));
    return {27'($urandom), shift};
  endfunction

  // Setup cycle, then access cycle; the register is written at the edge that ends the access.
  task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_gains(logic [APB_DATA_W-1:0] g0, logic [APB_DATA_W-1:0] g1,
                             logic [APB_DATA_W-1:0] g2, logic [APB_DATA_W-1:0] g3);
    write_register(REG_GAIN_CH0, g0);
    write_register(REG_GAIN_CH1, g1);
    write_register(REG_GAIN_CH2, g2);
    write_register(REG_GAIN_CH3, g3);
  endtask

  // Offers one item and holds it until accepted. Valid is only dropped when a gap follows,
  // so back-to-back items never see valid lowered and raised in the same time step.
  task automatic send_reading_set(qctp_in_t item, int unsigned gap);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent <= items_sent + 1;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_directed(logic [READING_BITS-1:0] a, logic [READING_BITS-1:0] b,
                               logic [READING_BITS-1:0] c, logic [READING_BITS-1:0] d);
    qctp_in_t item;
    item.reading_a = a;
    item.reading_b = b;
    item.reading_c = c;
    item.reading_d = d;
    send_reading_set(item, pick_gap(1'b0));
  endtask

  // Drops valid and waits until every predicted result has come back. The first edge lets
  // the checker count an item accepted at the edge the caller stopped on.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver side. Ready toggles in random stretches; once, after enough items have gone in,
  // it is held low for a long run so that all stages fill and the block stalls its input.
  initial begin
    bit          long_hold_done;
    int unsigned stall;
    long_hold_done = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!long_hold_done && items_sent >= HOLD_AT_ITEM) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if ($urandom_range(0, 9) < 2) begin
        // A stretch with no stalls at all.
        out_ready_i <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    qctp_in_t    item;
    bit          burst;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    items_sent <= 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: unit gains, no shift, no overflow correction.
    send_directed('0, '0, '0, '0);
    send_directed(READING_MAX, READING_MAX, READING_MAX, READING_MAX);
    send_directed(OVF_ONLY, OVF_ONLY, OVF_ONLY, OVF_ONLY);
    send_directed(OVF_BELOW, OVF_BELOW, OVF_BELOW, OVF_BELOW);
    send_directed(PATTERN_A, PATTERN_B, PATTERN_A, PATTERN_B);
    send_directed(PATTERN_B, PATTERN_A, PATTERN_B, PATTERN_A);
    wait_until_drained();

    // Correction on every channel and the gain extremes. Readings with the overflow bit clear
    // get doubled and keep their extra top bit.
    write_register(REG_SHIFT_AMOUNT, '0);
    write_register(REG_GUARD_MASK, 32'h0000_000F);
    write_gains(32'hFF80_0000, 32'h007F_FFFF, 32'h0001_0000, 32'hFFFF_0000);
    send_directed(READING_MAX, READING_MAX, READING_MAX, READING_MAX);
    send_directed(OVF_ONLY, OVF_ONLY, OVF_ONLY, OVF_ONLY);
    send_directed(OVF_BELOW, OVF_BELOW, OVF_BELOW, OVF_BELOW);
    send_directed(READING_MAX, OVF_BELOW, OVF_ONLY, 28'd1);
    wait_until_drained();

    // The largest shift wipes out every prepared reading.
    write_register(REG_GUARD_MASK, 32'h0000_0005);
    write_register(REG_SHIFT_AMOUNT, 32'h0000_001F);
    send_directed(READING_MAX, READING_MAX, READING_MAX, READING_MAX);
    send_directed(OVF_BELOW, OVF_BELOW, OVF_BELOW, OVF_BELOW);
    wait_until_drained();

    // Only channel 0 weighs in, negatively: a small negative sum whose quarter truncates to
    // zero must still clamp, while a zero sum must not.
    write_register(REG_SHIFT_AMOUNT, '0);
    write_register(REG_GUARD_MASK, '0);
    write_gains(32'hFFFF_0000, '0, '0, '0);
    send_directed(28'd2, '0, '0, '0);
    send_directed('0, '0, '0, '0);
    send_directed(28'd7, READING_MAX, READING_MAX, READING_MAX);
    wait_until_drained();

    // Writes past the last register are dropped; the previous settings still apply.
    write_register(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_register(REG_SPARE_HI, 32'h5A5A_A5A5);
    send_directed(READING_MAX, READING_MAX, READING_MAX, READING_MAX);
    wait_until_drained();

    // Random segments, each under fresh random settings. Some run with no input gaps.
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      write_register(REG_SHIFT_AMOUNT, pick_shift_word());
      write_register(REG_GUARD_MASK, APB_DATA_W'($urandom));
      write_gains(pick_gain_word(), pick_gain_word(), pick_gain_word(), pick_gain_word());
      burst = ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < SEGMENT_ITEMS; n++) begin
        item.reading_a = pick_reading();
        item.reading_b = pick_reading();
        item.reading_c = pick_reading();
        item.reading_d = pick_reading();
        send_reading_set(item, pick_gap(burst));
      end
      wait_until_drained();
    end

    // Any late, unexpected result would show up in the checker during this settling time.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
